// ===== rtl/core/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/c8x_pkg.sv =====
package c8x_pkg;
    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int STACK_ENTRIES_DEF = 16;
    localparam int FONT_SPRITE_BYTES_DEF = 5;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNIMPL = 2'd1;
    localparam logic [1:0] ST_STACK = 2'd2;
    localparam logic REG_FONT_START = 1'b0;
    localparam logic REG_PROGRAM_START = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_WAIT  = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_BLOCK = 8'b0001_0000,
        S_BLKW  = 8'b0010_0000,
        S_BCD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // write a load byte
        logic fetch_hi;  // latch byte at pc, read byte at pc+1
        logic fetch_lo;  // latch byte at pc+1
        logic exec;      // run the decoded instruction
        logic blk_step;  // one block store/load step
        logic blk_last;  // apply a block load read
        logic bcd_step;  // write one bcd digit
        logic start_blk; // clear step count
    } cmd_t;

    typedef struct packed {
        logic is_block;  // Fx55 or Fx65
        logic is_bcd;
        logic blk_done;
        logic bcd_done;
    } stat_t;
endpackage

// ===== rtl/core/c8x_ctrl.sv =====
`include "assert_macros.svh"
module c8x_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_cmd,
    input  logic           out_busy,
    input  c8x_pkg::stat_t st,
    output c8x_pkg::cmd_t  cmd,
    output logic           idle,
    output logic           done
);
    c8x_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= c8x_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            c8x_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd)
                    begin
                        cmd.load = 1'b1;
                        state_next = c8x_pkg::S_DONE;
                    end
                    else
                        state_next = c8x_pkg::S_FETCH;
                end
            end
            c8x_pkg::S_FETCH:
            begin
                cmd.fetch_hi = 1'b1;
                state_next = c8x_pkg::S_WAIT;
            end
            c8x_pkg::S_WAIT:
            begin
                cmd.fetch_lo = 1'b1;
                state_next = c8x_pkg::S_EXEC;
            end
            c8x_pkg::S_EXEC:
            begin
                cmd.start_blk = 1'b1;
                if (st.is_block)
                    state_next = c8x_pkg::S_BLOCK;
                else if (st.is_bcd)
                    state_next = c8x_pkg::S_BCD;
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = c8x_pkg::S_DONE;
                end
            end
            c8x_pkg::S_BLOCK:
            begin
                cmd.blk_step = 1'b1;
                state_next = c8x_pkg::S_BLKW;
            end
            c8x_pkg::S_BLKW:
            begin
                cmd.blk_last = 1'b1;
                if (st.blk_done)
                begin
                    cmd.exec = 1'b1;
                    state_next = c8x_pkg::S_DONE;
                end
                else
                    state_next = c8x_pkg::S_BLOCK;
            end
            c8x_pkg::S_BCD:
            begin
                cmd.bcd_step = 1'b1;
                if (st.bcd_done)
                begin
                    cmd.exec = 1'b1;
                    state_next = c8x_pkg::S_DONE;
                end
            end
            c8x_pkg::S_DONE:
            begin
                if (!out_busy)
                    state_next = c8x_pkg::S_IDLE;
            end
            default: state_next = c8x_pkg::S_IDLE;
        endcase
    end

    assign idle = state_reg == c8x_pkg::S_IDLE;
    assign done = state_reg == c8x_pkg::S_DONE;

    `ASSERT_NEXT(a_fetch_seq, clk, rst_n, state_reg == c8x_pkg::S_FETCH,
        state_reg == c8x_pkg::S_WAIT)
    `ASSERT_IMPL(a_exec_once, clk, rst_n, cmd.exec, !cmd.load && !cmd.fetch_hi)
    `ASSERT_IMPL(a_idle_fire, clk, rst_n, in_fire, idle)
endmodule

// ===== rtl/core/c8x_datapath.sv =====
module c8x_datapath
#(
    parameter int MEMORY_BYTES = c8x_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_ENTRIES = c8x_pkg::STACK_ENTRIES_DEF,
    parameter int FONT_SPRITE_BYTES = c8x_pkg::FONT_SPRITE_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  c8x_pkg::cmd_t  cmd,
    output c8x_pkg::stat_t st,
    input  logic           in_fire,
    input  logic [11:0]    in_addr,
    input  logic [7:0]     in_byte,
    input  logic [7:0]     in_rand,
    input  logic           cfg_we,
    input  logic           cfg_idx,
    input  logic [11:0]    cfg_data,
    output logic [11:0]    pc,
    output logic [15:0]    opcode,
    output logic [1:0]     status
);
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = $clog2(STACK_ENTRIES);
    localparam int DW = $clog2(STACK_ENTRIES + 1);

    logic [7:0]  mem [MEMORY_BYTES];
    logic [11:0] stack_mem [STACK_ENTRIES];
    logic [7:0]  v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg, font_reg;
    logic [DW-1:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [15:0] op_reg;
    logic [7:0]  rd_reg, rnd_reg;
    logic [11:0] stk_rd_reg;
    logic [3:0]  cnt_reg;
    logic [1:0]  status_reg;
    logic [7:0]  bcd_hund, bcd_tens, bcd_ones;

    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy;
    logic [11:0] nnn, pc2;
    assign x = op_reg[11:8];
    assign y = op_reg[7:4];
    assign n = op_reg[3:0];
    assign kk = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign pc2 = pc_reg + 12'd2;

    logic is_f;
    assign is_f = op_reg[15:12] == 4'hF;
    assign st.is_block = is_f && (kk == 8'h55 || kk == 8'h65);
    assign st.is_bcd = is_f && kk == 8'h33;
    assign st.blk_done = cnt_reg == x;
    assign st.bcd_done = cnt_reg == 4'd2;

    // memory port: one write, one registered read
    // the byte at pc is read at the accepting edge while idle
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;
    logic [15:0]   blk_addr;
    logic [7:0]    bcd_digit;
    assign blk_addr = i_reg + {12'd0, cnt_reg};

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    bcd_digit = bcd_hund;
            2'd1:    bcd_digit = bcd_tens;
            default: bcd_digit = bcd_ones;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = in_addr[AW-1:0];
        mem_wd = in_byte;
        mem_ra = pc_reg[AW-1:0];
        if (cmd.load)
            mem_we = 1'b1;
        else if (cmd.blk_step && kk == 8'h55)
        begin
            mem_we = 1'b1;
            mem_wa = blk_addr[AW-1:0];
            mem_wd = v_reg[cnt_reg];
        end
        else if (cmd.bcd_step)
        begin
            mem_we = 1'b1;
            mem_wa = blk_addr[AW-1:0];
            mem_wd = bcd_digit;
        end
        if (cmd.fetch_hi)
            mem_ra = pc_reg[AW-1:0] + AW'(1);
        else if (cmd.blk_step)
            mem_ra = blk_addr[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stack_mem[SW'(sp_reg - DW'(1))];
        if (cmd.exec && op_reg[15:12] == 4'h2 && sp_reg < DW'(STACK_ENTRIES))
            stack_mem[sp_reg[SW-1:0]] <= pc2;
        if (in_fire)
            rnd_reg <= in_rand;
    end

    // bcd digits of vx: hundreds by compare and subtract, tens by parallel threshold compares, ones by a subtract
    logic [7:0] h_r;
    always_comb
    begin
        h_r = vx;
        bcd_hund = 8'd0;
        if (h_r >= 8'd200)
        begin
            bcd_hund = 8'd2;
            h_r = h_r - 8'd200;
        end
        else if (h_r >= 8'd100)
        begin
            bcd_hund = 8'd1;
            h_r = h_r - 8'd100;
        end
        bcd_tens = 8'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (h_r >= 8'(10 * k))
                bcd_tens = 8'(k);
        end
        bcd_ones = h_r - ((bcd_tens << 3) + (bcd_tens << 1));
    end

    logic [8:0]  sum9;
    logic [15:0] font_addr;
    assign sum9 = {1'b0, vx} + {1'b0, vy};
    assign font_addr = {4'd0, font_reg} + 16'(FONT_SPRITE_BYTES * vx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                v_reg[k] <= 8'd0;
            i_reg <= 16'd0;
            pc_reg <= 12'd512;
            font_reg <= 12'd80;
            sp_reg <= '0;
            dt_reg <= 8'd0;
            st_reg <= 8'd0;
            op_reg <= 16'd0;
            cnt_reg <= 4'd0;
            status_reg <= c8x_pkg::ST_OK;
        end
        else
        begin
            // program_start only matters at reset, which restores it to 512
            if (cfg_we && cfg_idx == c8x_pkg::REG_FONT_START)
                font_reg <= cfg_data;
            if (cmd.load)
            begin
                op_reg <= 16'd0;
                status_reg <= c8x_pkg::ST_OK;
            end
            if (cmd.fetch_hi)
                op_reg[15:8] <= rd_reg;
            if (cmd.fetch_lo)
                op_reg[7:0] <= rd_reg;
            if (cmd.start_blk)
                cnt_reg <= 4'd0;
            if (cmd.blk_last && kk == 8'h65)
                v_reg[cnt_reg] <= rd_reg;
            if (cmd.blk_last && !st.blk_done)
                cnt_reg <= cnt_reg + 4'd1;
            if (cmd.bcd_step && !st.bcd_done)
                cnt_reg <= cnt_reg + 4'd1;
            if (cmd.exec)
            begin
                status_reg <= c8x_pkg::ST_OK;
                pc_reg <= pc2;
                unique case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == 16'h00EE)
                        begin
                            if (sp_reg == '0)
                                status_reg <= c8x_pkg::ST_STACK;
                            else
                            begin
                                sp_reg <= sp_reg - DW'(1);
                                pc_reg <= stk_rd_reg;
                            end
                        end
                        else
                            status_reg <= c8x_pkg::ST_UNIMPL;
                    end
                    4'h1: pc_reg <= nnn;
                    4'h2:
                    begin
                        if (sp_reg >= DW'(STACK_ENTRIES))
                            status_reg <= c8x_pkg::ST_STACK;
                        else
                        begin
                            sp_reg <= sp_reg + DW'(1);
                            pc_reg <= nnn;
                        end
                    end
                    4'h3: if (vx == kk) pc_reg <= pc_reg + 12'd4;
                    4'h4: if (vx != kk) pc_reg <= pc_reg + 12'd4;
                    4'h5:
                    begin
                        if (n != 4'd0)
                            status_reg <= c8x_pkg::ST_UNIMPL;
                        else if (vx == vy)
                            pc_reg <= pc_reg + 12'd4;
                    end
                    4'h6: v_reg[x] <= kk;
                    4'h7: v_reg[x] <= vx + kk;
                    4'h8:
                    begin
                        unique case (n)
                            4'h0: v_reg[x] <= vy;
                            4'h1: v_reg[x] <= vx | vy;
                            4'h2: v_reg[x] <= vx & vy;
                            4'h3: v_reg[x] <= vx ^ vy;
                            4'h4:
                            begin
                                v_reg[x] <= sum9[7:0];
                                v_reg[15] <= {7'd0, sum9[8]};
                            end
                            4'h5:
                            begin
                                v_reg[x] <= vx - vy;
                                v_reg[15] <= {7'd0, vx > vy};
                            end
                            4'h6:
                            begin
                                v_reg[x] <= {1'b0, vx[7:1]};
                                v_reg[15] <= {7'd0, vx[0]};
                            end
                            4'h7:
                            begin
                                v_reg[x] <= vy - vx;
                                v_reg[15] <= {7'd0, vy > vx};
                            end
                            4'hE:
                            begin
                                v_reg[x] <= {vx[6:0], 1'b0};
                                v_reg[15] <= {7'd0, vx[7]};
                            end
                            default: status_reg <= c8x_pkg::ST_UNIMPL;
                        endcase
                    end
                    4'h9:
                    begin
                        if (n != 4'd0)
                            status_reg <= c8x_pkg::ST_UNIMPL;
                        else if (vx != vy)
                            pc_reg <= pc_reg + 12'd4;
                    end
                    4'hA: i_reg <= {4'd0, nnn};
                    4'hB: pc_reg <= nnn + {4'd0, v_reg[0]};
                    4'hC: v_reg[x] <= rnd_reg & kk;
                    4'hF:
                    begin
                        unique case (kk)
                            8'h07: v_reg[x] <= dt_reg;
                            8'h15: dt_reg <= vx;
                            8'h18: st_reg <= vx;
                            8'h1E: i_reg <= i_reg + {8'd0, vx};
                            8'h29: i_reg <= font_addr;
                            8'h33, 8'h55, 8'h65: ;
                            default: status_reg <= c8x_pkg::ST_UNIMPL;
                        endcase
                    end
                    default: status_reg <= c8x_pkg::ST_UNIMPL;
                endcase
            end
        end
    end

    assign pc = pc_reg;
    assign opcode = op_reg;
    assign status = status_reg;
endmodule

// ===== rtl/core/chip8_instruction_execute.sv =====
// chip-8 instruction core
// s_axis: one request per item; tdata = command, load_address, load_byte,
// random_byte from the lowest bit up; accepted when tvalid and tready high
// m_axis: one result per request; tdata = next_pc, executed_opcode, status
// a load request goes straight to its result; an execute fetches the two
// opcode bytes and then runs; a bcd writes three digits, and a block store or
// load moves registers 0 to x one at a time, all through the single memory port
// the next request is taken once the result register has been emptied
// the result is held while m_axis_tready is low
// reset clears registers, stack depth and index; pc takes 512 and
// font_start 80; memory and call stack keep their contents
// cfg: cfg_we with cfg_addr 0 font_start, 1 program_start; program_start
// is not stored, so a write to it has no effect; every reset sets pc to 512
module chip8_instruction_execute
#(
    parameter int MEMORY_BYTES = c8x_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_ENTRIES = c8x_pkg::STACK_ENTRIES_DEF,
    parameter int FONT_SPRITE_BYTES = c8x_pkg::FONT_SPRITE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // command, load_address, load_byte, random_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // next_pc, executed_opcode, status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_data
);
    c8x_pkg::cmd_t  cmd;
    c8x_pkg::stat_t st;
    logic idle, done, in_fire, ov_reg;
    logic [11:0] pc;
    logic [15:0] opcode;
    logic [1:0]  status;

    assign s_axis_tready = idle && !ov_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    c8x_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(s_axis_tdata[0]),
        .out_busy(ov_reg), .st(st), .cmd(cmd), .idle(idle), .done(done)
    );

    c8x_datapath #(
        .MEMORY_BYTES(MEMORY_BYTES), .STACK_ENTRIES(STACK_ENTRIES),
        .FONT_SPRITE_BYTES(FONT_SPRITE_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .in_fire(in_fire),
        .in_addr(s_axis_tdata[12:1]), .in_byte(s_axis_tdata[20:13]),
        .in_rand(s_axis_tdata[28:21]), .cfg_we(cfg_we), .cfg_idx(cfg_addr),
        .cfg_data(cfg_data), .pc(pc), .opcode(opcode), .status(status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done && !ov_reg)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {2'd0, status, opcode, pc};
endmodule
